### design/hjc_pkg.sv
package hjc_pkg;

  localparam int LOG2_SLOTS = 16;
  localparam int SLOT_DEPTH = 1 << LOG2_SLOTS;
  localparam int IDX_W = LOG2_SLOTS;
  localparam int CNT_W = IDX_W + 1;
  localparam int SB_W = 5;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [31:0] RESERVED_KEY = 32'h8000_0000;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [62:0] TOTAL_MAX = {63{1'b1}};

  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_PROBE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RSVD = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic        end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [31:0] match_count;
    logic [62:0] total_matches;
    logic [1:0]  status;
    logic        answer_ready;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch input item, compute home slot
    logic rd;        // issue read of current slot
    logic advance;   // step to next slot
    logic ins;       // write new entry at current slot
    logic inc;       // increment count at current slot
    logic hit;       // add matched count to total
    logic clr_step;  // clear one valid entry
    logic clr_start;
    logic clr_total;
  } hjc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        slot_valid;
    logic        key_eq;
    logic        pass_done;
    logic        clr_done;
    logic [1:0]  kind;
    logic        rsvd;
  } hjc_sts_t;

endpackage

### design/hjc_if.sv
interface hjc_in_if;
  logic               valid;
  logic               ready;
  hjc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hjc_out_if;
  logic               valid;
  logic               ready;
  hjc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/hjc_datapath.sv
module hjc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hjc_pkg::hjc_cmd_t             cmd,
  output hjc_pkg::hjc_sts_t             sts,
  input  hjc_pkg::in_item_t             in_item,
  input  logic [hjc_pkg::SB_W-1:0]      slot_bits_cfg,
  output logic [31:0]                   match_r,
  output logic [62:0]                   total_r
);

  logic        valid_mem [hjc_pkg::SLOT_DEPTH];
  logic [31:0] key_mem [hjc_pkg::SLOT_DEPTH];
  logic [31:0] cnt_mem [hjc_pkg::SLOT_DEPTH];

  logic [1:0]  kind_r;
  logic [31:0] key_r;
  logic [hjc_pkg::IDX_W-1:0] idx_r, mask_r, clr_idx_r;
  logic [hjc_pkg::CNT_W-1:0] n_r, nslots_r;
  logic [31:0] rkey_r, rcnt_r;
  logic        rvalid_r;
  logic        clr_done_r;

  logic [4:0]  ub;
  logic [hjc_pkg::IDX_W-1:0] mask_c;
  logic [hjc_pkg::CNT_W-1:0] nslots_c;
  logic [31:0] prod;
  logic [63:0] sum_c;

  always_comb begin
    ub = slot_bits_cfg;
    if (ub < 5'd1) ub = 5'd1;
    if (ub > 5'(hjc_pkg::LOG2_SLOTS)) ub = 5'(hjc_pkg::LOG2_SLOTS);
    nslots_c = hjc_pkg::CNT_W'(1) << ub;
    mask_c = hjc_pkg::IDX_W'(nslots_c - hjc_pkg::CNT_W'(1));
    // only the low product bits reach the slot index
    prod = in_item.key * hjc_pkg::HASH_MULT;
    sum_c = {1'b0, total_r} + {32'd0, rcnt_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_item.kind;
      key_r <= in_item.key;
      idx_r <= prod[hjc_pkg::IDX_W-1:0] & mask_c;
      mask_r <= mask_c;
      nslots_r <= nslots_c;
      n_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= (idx_r + hjc_pkg::IDX_W'(1)) & mask_r;
      n_r <= n_r + hjc_pkg::CNT_W'(1);
    end
    if (cmd.rd) begin
      rkey_r <= key_mem[idx_r];
      rcnt_r <= cnt_mem[idx_r];
      rvalid_r <= valid_mem[idx_r];
    end
    if (cmd.ins) begin
      key_mem[idx_r] <= key_r;
      cnt_mem[idx_r] <= 32'd1;
    end else if (cmd.inc && rcnt_r != hjc_pkg::COUNT_MAX) begin
      cnt_mem[idx_r] <= rcnt_r + 32'd1;
    end
    if (cmd.ins) valid_mem[idx_r] <= 1'b1;
    else if (cmd.clr_step) valid_mem[clr_idx_r] <= 1'b0;
    if (cmd.load) match_r <= '0;
    else if (cmd.hit) match_r <= rcnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      clr_idx_r <= '0;
      clr_done_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_idx_r <= '0;
        clr_done_r <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + hjc_pkg::IDX_W'(1);
        if (clr_idx_r == '1) clr_done_r <= 1'b1;
      end
      if (cmd.clr_total) total_r <= '0;
      else if (cmd.hit) total_r <= sum_c[63] ? hjc_pkg::TOTAL_MAX : sum_c[62:0];
    end
  end

  assign sts.slot_valid = rvalid_r;
  assign sts.key_eq = rkey_r == key_r;
  assign sts.pass_done = n_r == nslots_r;
  assign sts.clr_done = clr_done_r;
  assign sts.kind = kind_r;
  assign sts.rsvd = key_r == hjc_pkg::RESERVED_KEY;

endmodule

### design/hjc_ctrl.sv
module hjc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hjc_pkg::hjc_cmd_t cmd,
  input  hjc_pkg::hjc_sts_t sts,
  output logic [1:0]        status_r,
  output logic              eos_r,
  input  logic              in_eos
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_INIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] status_nxt;
  logic       eos_nxt;

  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    eos_nxt = eos_r;
    cmd = '0;
    case (state_r)
      S_INIT: begin
        // sweep the valid bits once after reset
        if (sts.clr_done) state_nxt = S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          eos_nxt = in_eos;
          status_nxt = hjc_pkg::ST_OK;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.kind == hjc_pkg::KIND_CLEAR) begin
          cmd.clr_start = 1'b1;
          cmd.clr_total = 1'b1;
          state_nxt = S_CLR;
        end else if (sts.kind == hjc_pkg::KIND_BUILD || sts.kind == hjc_pkg::KIND_PROBE) begin
          if (sts.rsvd) begin
            status_nxt = hjc_pkg::ST_RSVD;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          state_nxt = S_OUT;
        end
        if (sts.kind != hjc_pkg::KIND_PROBE) eos_nxt = 1'b0;
      end
      S_READ: begin
        if (sts.pass_done) begin
          if (sts.kind == hjc_pkg::KIND_BUILD) status_nxt = hjc_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.slot_valid) begin
          if (sts.kind == hjc_pkg::KIND_BUILD) cmd.ins = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.key_eq) begin
          if (sts.kind == hjc_pkg::KIND_BUILD) cmd.inc = 1'b1;
          else cmd.hit = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_CLR: begin
        if (sts.clr_done) state_nxt = S_OUT;
        else cmd.clr_step = 1'b1;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      status_r <= hjc_pkg::ST_OK;
      eos_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      eos_r <= eos_nxt;
    end
  end

endmodule

### design/hash_join_count_engine.sv
// A build or probe reads its home slot first and then walks on slot by slot until it
// resolves or has tried every slot; a reserved key or unused kind goes to the result.
// A clear sweeps the valid bits of all 2^LOG2_SLOTS slots, one valid bit per cycle.
// One item in flight; the next transfer is taken the cycle after the result
// transfer. Synchronous active-low reset zeroes the total, sets slot_bits to 16
// and sweeps every valid bit of the table.
module hash_join_count_engine (
  input  logic       clk,
  input  logic       rst_n,
  hjc_in_if.sink     in_ch,
  hjc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  hjc_pkg::hjc_cmd_t cmd;
  hjc_pkg::hjc_sts_t sts;
  logic [hjc_pkg::SB_W-1:0] slot_bits_r;
  logic [31:0] match;
  logic [62:0] total;
  logic [1:0]  status;
  logic        eos;

  always_ff @(posedge clk) begin
    if (!rst_n) slot_bits_r <= 5'd16;
    else if (cfg_we) slot_bits_r <= cfg_wdata;
  end

  hjc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts, .status_r(status), .eos_r(eos),
    .in_eos(in_ch.data.end_of_set)
  );

  hjc_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_item(in_ch.data), .slot_bits_cfg(slot_bits_r),
    .match_r(match), .total_r(total)
  );

  assign out_ch.data.match_count = match;
  assign out_ch.data.total_matches = total;
  assign out_ch.data.status = status;
  assign out_ch.data.answer_ready = eos;

endmodule
